[rtl/fda_pkg.sv]
package fda_pkg;

   localparam int SLOT_COUNT_DEF   = 16;
   localparam int COLUMN_COUNT_DEF = 32;
   localparam int ROW_COUNT        = 8;

   localparam int FIRST_CHANCE  = 35;
   localparam int SECOND_CHANCE = 60;
   localparam int ROLL_W        = 7;

   // Number of distinct values of the spawn column field.
   localparam int SPAWN_COL_SPAN = 32;

   typedef enum logic [1:0] {
      KIND_TICK    = 2'd0,
      KIND_RESTART = 2'd1,
      KIND_ADD     = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   // Commands to the column image store.
   typedef struct packed {
      logic load;   // read a column for a following merge
      logic merge;  // write back the column read last, ORed with the mask
      logic take;   // read a column for output and mark it empty
   } img_ctl_type;

endpackage

[rtl/falling_drop_animator_top.sv]
// Restart clears all slots and an add word runs the first spawn only; neither gives results.
// A frame tick walks the slot memory one slot at a time: a free slot is skipped, a drop that
// leaves the display is read and dropped, and a drop that is drawn is read and drawn (slot read,
// image read-modify-write); then come both spawn steps, a read and a write per column, and idle.
// The output pass waits while the receiver stalls. Reset is synchronous, active high.
module falling_drop_animator_top import fda_pkg::*; #(
   parameter int SLOT_COUNT   = SLOT_COUNT_DEF,
   parameter int COLUMN_COUNT = COLUMN_COUNT_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic [6:0] req_roll_first,
   input  logic [6:0] req_roll_second,
   input  logic [4:0] req_spawn_a_column,
   input  logic [2:0] req_spawn_a_rise,
   input  logic [2:0] req_spawn_a_length,
   input  logic [1:0] req_spawn_a_speed,
   input  logic [4:0] req_spawn_b_column,
   input  logic [2:0] req_spawn_b_rise,
   input  logic [2:0] req_spawn_b_length,
   input  logic [1:0] req_spawn_b_speed,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_column_index,
   output logic [7:0] rsp_column_pixels,
   output logic       rsp_last_column
);

   localparam int COL_W  = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1;
   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

   // One drop slot as it is kept in the slot memory. A slot is live when its bit in
   // live_ff is set; the memory itself is never cleared.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic signed [3:0] top;
      logic [2:0]       len;
      logic [1:0]       speed;
      logic [1:0]       count;
   } slot_type;

   typedef enum logic [7:0] {
      S_IDLE     = 8'b0000_0001,
      S_SLOT_RD  = 8'b0000_0010,
      S_SLOT_UPD = 8'b0000_0100,
      S_DRAW     = 8'b0000_1000,
      S_SPAWN_A  = 8'b0001_0000,
      S_SPAWN_B  = 8'b0010_0000,
      S_EMIT_RD  = 8'b0100_0000,
      S_EMIT_WR  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // The request word is held here while the frame is worked on.
   logic             frame_ff, frame_in;
   logic [6:0]       roll_first_ff, roll_first_in;
   logic [6:0]       roll_second_ff, roll_second_in;
   logic [4:0]       a_col_ff, a_col_in;
   logic [2:0]       a_rise_ff, a_rise_in;
   logic [2:0]       a_len_ff, a_len_in;
   logic [1:0]       a_speed_ff, a_speed_in;
   logic [4:0]       b_col_ff, b_col_in;
   logic [2:0]       b_rise_ff, b_rise_in;
   logic [2:0]       b_len_ff, b_len_in;
   logic [1:0]       b_speed_ff, b_speed_in;

   logic [SLOT_COUNT-1:0] live_ff, live_in;
   logic [CNT_W-1:0]      live_count_ff, live_count_in;
   logic [SLOT_W-1:0]     slot_idx_ff, slot_idx_in;
   logic [COL_W-1:0]      emit_idx_ff, emit_idx_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [4:0]       rsp_index_ff, rsp_index_in;
   logic [7:0]       rsp_pixels_ff, rsp_pixels_in;
   logic             rsp_last_ff, rsp_last_in;

   // Slot memory, one write and one registered read port.
   slot_type         slot_mem_ff [SLOT_COUNT];
   slot_type         slot_rd_ff;
   logic             slot_rd_en;
   logic             slot_wr_en;
   logic [SLOT_W-1:0] slot_wr_addr;
   slot_type         slot_wr_data;

   img_ctl_type          img_ctl;
   logic [COL_W-1:0]     img_addr;
   logic [ROW_COUNT-1:0] img_rd_data;

   logic                 accept;
   logic                 rsp_free;
   logic                 slot_last;
   logic                 emit_last;
   logic [SLOT_W-1:0]    free_idx;
   logic [COL_W-1:0]     col_mod [SPAWN_COL_SPAN];
   logic [COL_W+4:0]     emit_ext;

   // Slot update terms, all taken from the slot word read last.
   logic [2:0]           cnt_up;
   logic                 move;
   logic signed [5:0]    top_ext;
   logic signed [5:0]    top_next;
   logic signed [5:0]    bottom;
   logic                 gone;
   logic [ROW_COUNT-1:0] drop_mask;
   slot_type             slot_upd;

   logic                 spawn_a_go;
   logic                 spawn_b_go;
   slot_type             spawn_a_slot;
   slot_type             spawn_b_slot;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign slot_last = (slot_idx_ff == SLOT_W'(SLOT_COUNT - 1));
   assign emit_last = (emit_idx_ff == COL_W'(COLUMN_COUNT - 1));
   assign emit_ext  = {5'b0, emit_idx_ff};

   // Reduction of a spawn column to the display width, worked out at elaboration.
   for (genvar g = 0; g < SPAWN_COL_SPAN; g++) begin : g_col_mod
      assign col_mod[g] = COL_W'(g % COLUMN_COUNT);
   end

   // Lowest free slot.
   always_comb begin
      free_idx = '0;
      for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
         if (!live_ff[i]) begin
            free_idx = SLOT_W'(i);
         end
      end
   end

   // A drop moves one row once its counter reaches its speed, and it leaves the slot
   // table when its top row has passed the bottom of the display.
   always_comb begin
      cnt_up   = {1'b0, slot_rd_ff.count} + 3'd1;
      move     = (cnt_up >= {1'b0, slot_rd_ff.speed});
      top_ext  = {{2{slot_rd_ff.top[3]}}, slot_rd_ff.top};
      top_next = move ? (top_ext + 6'sd1) : top_ext;
      gone     = move && (top_next >= 6'sd8);
      bottom   = top_next + $signed({3'b000, slot_rd_ff.len});
      for (int r = 0; r < ROW_COUNT; r++) begin
         drop_mask[r] = (top_next <= $signed(6'(r))) && ($signed(6'(r)) < bottom);
      end
      slot_upd       = slot_rd_ff;
      slot_upd.top   = top_next[3:0];
      slot_upd.count = move ? 2'd0 : cnt_up[1:0];
   end

   // The first spawn is not rolled for an add word and rolled on a frame tick; both spawns
   // need a free slot and a nonzero length; the second needs under half the slots live, counted after the first.
   always_comb begin
      spawn_a_go = (!frame_ff || (roll_first_ff < ROLL_W'(FIRST_CHANCE)))
                   && (live_count_ff < CNT_W'(SLOT_COUNT)) && (a_len_ff != 3'd0);
      spawn_b_go = (live_count_ff < CNT_W'(SLOT_COUNT / 2))
                   && (roll_second_ff < ROLL_W'(SECOND_CHANCE)) && (b_len_ff != 3'd0);
      spawn_a_slot.col   = col_mod[a_col_ff];
      spawn_a_slot.top   = -$signed({1'b0, a_rise_ff});
      spawn_a_slot.len   = a_len_ff;
      spawn_a_slot.speed = a_speed_ff;
      spawn_a_slot.count = 2'd0;
      spawn_b_slot.col   = col_mod[b_col_ff];
      spawn_b_slot.top   = -$signed({1'b0, b_rise_ff});
      spawn_b_slot.len   = b_len_ff;
      spawn_b_slot.speed = b_speed_ff;
      spawn_b_slot.count = 2'd0;
   end

   always_comb begin
      state_in       = state_ff;
      frame_in       = frame_ff;
      roll_first_in  = roll_first_ff;
      roll_second_in = roll_second_ff;
      a_col_in       = a_col_ff;
      a_rise_in      = a_rise_ff;
      a_len_in       = a_len_ff;
      a_speed_in     = a_speed_ff;
      b_col_in       = b_col_ff;
      b_rise_in      = b_rise_ff;
      b_len_in       = b_len_ff;
      b_speed_in     = b_speed_ff;
      live_in        = live_ff;
      live_count_in  = live_count_ff;
      slot_idx_in    = slot_idx_ff;
      emit_idx_in    = emit_idx_ff;
      slot_rd_en     = 1'b0;
      slot_wr_en     = 1'b0;
      slot_wr_addr   = slot_idx_ff;
      slot_wr_data   = slot_upd;
      img_ctl        = '0;
      img_addr       = slot_rd_ff.col;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_index_in   = rsp_index_ff;
      rsp_pixels_in  = rsp_pixels_ff;
      rsp_last_in    = rsp_last_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               roll_first_in  = req_roll_first;
               roll_second_in = req_roll_second;
               a_col_in       = req_spawn_a_column;
               a_rise_in      = req_spawn_a_rise;
               a_len_in       = req_spawn_a_length;
               a_speed_in     = req_spawn_a_speed;
               b_col_in       = req_spawn_b_column;
               b_rise_in      = req_spawn_b_rise;
               b_len_in       = req_spawn_b_length;
               b_speed_in     = req_spawn_b_speed;
               slot_idx_in    = '0;
               unique case (kind_type'(req_kind))
                  KIND_TICK: begin
                     frame_in = 1'b1;
                     state_in = S_SLOT_RD;
                  end
                  KIND_RESTART: begin
                     live_in       = '0;
                     live_count_in = '0;
                  end
                  KIND_ADD: begin
                     frame_in = 1'b0;
                     state_in = S_SPAWN_A;
                  end
                  KIND_UNUSED: begin
                  end
               endcase
            end
         end
         S_SLOT_RD: begin
            // Free slots are skipped without a memory read.
            if (live_ff[slot_idx_ff]) begin
               slot_rd_en = 1'b1;
               state_in   = S_SLOT_UPD;
            end else if (slot_last) begin
               state_in = S_SPAWN_A;
            end else begin
               slot_idx_in = slot_idx_ff + SLOT_W'(1);
            end
         end
         S_SLOT_UPD: begin
            if (gone) begin
               live_in[slot_idx_ff] = 1'b0;
               live_count_in        = live_count_ff - CNT_W'(1);
               if (slot_last) begin
                  state_in = S_SPAWN_A;
               end else begin
                  slot_idx_in = slot_idx_ff + SLOT_W'(1);
                  state_in    = S_SLOT_RD;
               end
            end else begin
               slot_wr_en   = 1'b1;
               img_ctl.load = 1'b1;
               state_in     = S_DRAW;
            end
         end
         S_DRAW: begin
            // The next load of any column comes no earlier than the following S_SLOT_UPD, after an
            // S_SLOT_RD, so it always sees this merge.
            img_ctl.merge = 1'b1;
            if (slot_last) begin
               state_in = S_SPAWN_A;
            end else begin
               slot_idx_in = slot_idx_ff + SLOT_W'(1);
               state_in    = S_SLOT_RD;
            end
         end
         S_SPAWN_A: begin
            if (spawn_a_go) begin
               slot_wr_en        = 1'b1;
               slot_wr_addr      = free_idx;
               slot_wr_data      = spawn_a_slot;
               live_in[free_idx] = 1'b1;
               live_count_in     = live_count_ff + CNT_W'(1);
            end
            state_in = frame_ff ? S_SPAWN_B : S_IDLE;
         end
         S_SPAWN_B: begin
            if (spawn_b_go) begin
               slot_wr_en        = 1'b1;
               slot_wr_addr      = free_idx;
               slot_wr_data      = spawn_b_slot;
               live_in[free_idx] = 1'b1;
               live_count_in     = live_count_ff + CNT_W'(1);
            end
            emit_idx_in = '0;
            state_in    = S_EMIT_RD;
         end
         S_EMIT_RD: begin
            // Reading a column for output also empties it for the next frame.
            img_ctl.take = 1'b1;
            img_addr     = emit_idx_ff;
            state_in     = S_EMIT_WR;
         end
         S_EMIT_WR: begin
            img_addr = emit_idx_ff;
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_index_in  = emit_ext[4:0];
               rsp_pixels_in = img_rd_data;
               rsp_last_in   = emit_last;
               if (emit_last) begin
                  state_in = S_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + COL_W'(1);
                  state_in    = S_EMIT_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (slot_rd_en) begin
         slot_rd_ff <= slot_mem_ff[slot_idx_ff];
      end
      if (slot_wr_en) begin
         slot_mem_ff[slot_wr_addr] <= slot_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff       <= frame_in;
      roll_first_ff  <= roll_first_in;
      roll_second_ff <= roll_second_in;
      a_col_ff       <= a_col_in;
      a_rise_ff      <= a_rise_in;
      a_len_ff       <= a_len_in;
      a_speed_ff     <= a_speed_in;
      b_col_ff       <= b_col_in;
      b_rise_ff      <= b_rise_in;
      b_len_ff       <= b_len_in;
      b_speed_ff     <= b_speed_in;
      slot_idx_ff    <= slot_idx_in;
      emit_idx_ff    <= emit_idx_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_pixels_ff  <= rsp_pixels_in;
      rsp_last_ff    <= rsp_last_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         live_ff       <= '0;
         live_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         live_ff       <= live_in;
         live_count_ff <= live_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   fda_column_store #(
      .COLUMN_COUNT (COLUMN_COUNT)
   ) u_column_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (img_ctl),
      .addr    (img_addr),
      .mask    (drop_mask),
      .rd_data (img_rd_data)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_column_index  = rsp_index_ff;
   assign rsp_column_pixels = rsp_pixels_ff;
   assign rsp_last_column   = rsp_last_ff;

`ifndef SYNTHESIS
   // The live count always matches the live slot bits.
   assert property (@(posedge clock) disable iff (reset)
      live_count_ff == CNT_W'($countones(live_ff)))
      else $error("live count differs from live slot bits");

   // A new output word is only loaded from the output pass.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_EMIT_WR))
      else $error("output word loaded outside the output pass");

   // An image merge always follows the load of the same slot's column.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DRAW) |-> $past(state_ff == S_SLOT_UPD))
      else $error("image merge without a preceding load");
`endif

endmodule

[rtl/fda_column_store.sv]
module fda_column_store import fda_pkg::*; #(
   parameter int COLUMN_COUNT = COLUMN_COUNT_DEF,
   localparam int COL_W = (COLUMN_COUNT > 1) ? $clog2(COLUMN_COUNT) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  img_ctl_type          ctl,
   input  logic [COL_W-1:0]     addr,
   input  logic [ROW_COUNT-1:0] mask,
   output logic [ROW_COUNT-1:0] rd_data
);

   logic [ROW_COUNT-1:0]    mem_ff [COLUMN_COUNT];
   logic [COLUMN_COUNT-1:0] vld_ff;
   logic [COLUMN_COUNT-1:0] vld_in;
   logic [ROW_COUNT-1:0]    rd_data_ff;

   // A column without its valid bit reads as empty, so the image needs no clearing pass.
   always_comb begin
      vld_in = vld_ff;
      if (ctl.merge) begin
         vld_in[addr] = 1'b1;
      end
      if (ctl.take) begin
         vld_in[addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load || ctl.take) begin
         rd_data_ff <= vld_ff[addr] ? mem_ff[addr] : '0;
      end
      if (ctl.merge) begin
         mem_ff[addr] <= rd_data_ff | mask;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rd_data = rd_data_ff;

endmodule
